// ===== src/coo2csr_pkg.sv =====
package coo2csr_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF    = 4096;

  localparam int unsigned NV_W     = 11;
  localparam int unsigned VERTEX_W = 10;
  localparam int unsigned WEIGHT_W = 64;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ERR_W    = 2;

  localparam logic [NV_W-1:0] NV_RESET = 11'd1024;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFSET = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_RANGE     = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_NOT_READY = 2'd3
  } err_e;

endpackage

// ===== src/coo2csr_ram.sv =====
module coo2csr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/coo_to_csr_builder_unit.sv =====
// Load item: result from LDINC (LOAD for a dropped edge); drain item: offset from DRDEG, sorted
// edge via DRIDX then DRARR, not-ready status from IDLE; a new item is taken as the strobe ends.
// Last edge then runs a prefix sum over all vertices and a scatter of the kept edges, block busy.
// A load after a drain first clears num_vertices+1 degree entries, one per cycle.
// Reset: asynchronous, active low; then degree entries 0..NV_RESET_EFF are cleared (busy high).
// Results are strobed for one cycle each; the receiver cannot stall them.
module coo_to_csr_builder_unit #(
  parameter int unsigned MAX_VERTICES = coo2csr_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = coo2csr_pkg::MAX_EDGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [coo2csr_pkg::NV_W-1:0]        cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                req_type_i,
  input  logic [coo2csr_pkg::VERTEX_W-1:0]    head_i,
  input  logic [coo2csr_pkg::VERTEX_W-1:0]    tail_i,
  input  logic [coo2csr_pkg::WEIGHT_W-1:0]    weight_bits_i,
  input  logic                                last_edge_i,
  output logic                                result_valid_o,
  output logic [coo2csr_pkg::KIND_W-1:0]      result_kind_o,
  output logic [coo2csr_pkg::OFFSET_W-1:0]    offset_value_o,
  output logic [coo2csr_pkg::VERTEX_W-1:0]    edge_head_o,
  output logic [coo2csr_pkg::VERTEX_W-1:0]    edge_tail_o,
  output logic [coo2csr_pkg::WEIGHT_W-1:0]    edge_weight_o,
  output logic                                last_result_o,
  output logic [coo2csr_pkg::ERR_W-1:0]       error_code_o
);

  import coo2csr_pkg::*;

  // Degree store holds entries 0..MAX_VERTICES, so its counter can hold MAX_VERTICES itself.
  localparam int unsigned VAW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CAW = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NV_RESET_EFF =
    (NV_RESET == '0) ? 1 : ((NV_RESET > MAX_VERTICES) ? MAX_VERTICES : NV_RESET);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CLEAR = 12'b0000_0000_0010,
    ST_LOAD  = 12'b0000_0000_0100,
    ST_LDINC = 12'b0000_0000_1000,
    ST_PFRD  = 12'b0000_0001_0000,
    ST_PFWR  = 12'b0000_0010_0000,
    ST_SCRD  = 12'b0000_0100_0000,
    ST_SCCUR = 12'b0000_1000_0000,
    ST_SCWR  = 12'b0001_0000_0000,
    ST_DRDEG = 12'b0010_0000_0000,
    ST_DRIDX = 12'b0100_0000_0000,
    ST_DRARR = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    PH_LOADING  = 3'b001,
    PH_DRAINING = 3'b010,
    PH_DONE     = 3'b100
  } phase_e;

  typedef struct packed {
    logic [VERTEX_W-1:0] head;
    logic [VERTEX_W-1:0] tail;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [OFFSET_W-1:0] offset;
    logic [VERTEX_W-1:0] head;
    logic [VERTEX_W-1:0] tail;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
    err_e                err;
  } res_t;

  // Control state
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [NV_W-1:0] cfg_nv_q;
  logic [VAW-1:0]  nv_q, nv_d;          // vertex count latched at load start
  logic [VAW-1:0]  vtx_q, vtx_d;        // clear, prefix and offset-drain walk
  logic [CW-1:0]   edg_q, edg_d;        // scatter and edge-drain walk
  logic [CW-1:0]   loaded_q, loaded_d;
  logic [CW-1:0]   sum_q, sum_d;        // running prefix sum
  logic [CAW-1:0]  hd_q, hd_d;          // head of the edge being scattered
  logic            in_edges_q, in_edges_d;
  logic            clr_load_q, clr_load_d;
  res_t            res_q, res_d;

  // Captured input item
  logic [VERTEX_W-1:0] it_head_q, it_tail_q;
  logic [WEIGHT_W-1:0] it_weight_q;
  logic                it_last_q;

  // Memory ports
  logic           deg_we;
  logic [VAW-1:0] deg_waddr, deg_raddr;
  logic [CW-1:0]  deg_wdata, deg_rdata;
  logic           cur_we;
  logic [CAW-1:0] cur_waddr, cur_raddr;
  logic [CW-1:0]  cur_wdata, cur_rdata;
  logic           arr_we;
  logic [EAW-1:0] arr_waddr, arr_raddr;
  edge_t          arr_wdata, arr_rdata;
  logic           idx_we;
  logic [EAW-1:0] idx_waddr, idx_raddr;
  logic [EAW-1:0] idx_wdata, idx_rdata;

  logic           accept;
  logic [VAW-1:0] nv_eff;
  logic           in_range;
  logic           store_full;
  logic [VAW-1:0] head_slot;
  logic [VAW-1:0] vtx_m1;
  logic [CW-1:0]  sum_new;
  logic           edg_is_last;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign in_range    = (32'(it_head_q) < 32'(nv_q)) && (32'(it_tail_q) < 32'(nv_q));
  assign store_full  = (loaded_q == CW'(MAX_EDGES));
  assign head_slot   = VAW'(it_head_q) + VAW'(1);
  assign vtx_m1      = vtx_q - VAW'(1);
  assign sum_new     = sum_q + deg_rdata;
  assign edg_is_last = ((edg_q + CW'(1)) == loaded_q);

  // Clamp the configured vertex count into 1..MAX_VERTICES
  always_comb begin
    if (cfg_nv_q == '0) begin
      nv_eff = VAW'(1);
    end else if (32'(cfg_nv_q) > MAX_VERTICES) begin
      nv_eff = VAW'(MAX_VERTICES);
    end else begin
      nv_eff = VAW'(cfg_nv_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    nv_d       = nv_q;
    vtx_d      = vtx_q;
    edg_d      = edg_q;
    loaded_d   = loaded_q;
    sum_d      = sum_q;
    hd_d       = hd_q;
    in_edges_d = in_edges_q;
    clr_load_d = clr_load_q;
    res_d      = '0;

    deg_we    = 1'b0;
    deg_waddr = vtx_q;
    deg_wdata = '0;
    deg_raddr = vtx_q;
    cur_we    = 1'b0;
    cur_waddr = vtx_m1[CAW-1:0];
    cur_wdata = sum_q;
    cur_raddr = hd_q;
    arr_we    = 1'b0;
    arr_waddr = loaded_q[EAW-1:0];
    arr_wdata = '{head: it_head_q, tail: it_tail_q, weight: it_weight_q};
    arr_raddr = edg_q[EAW-1:0];
    idx_we    = 1'b0;
    idx_waddr = cur_rdata[EAW-1:0];
    idx_wdata = edg_q[EAW-1:0];
    idx_raddr = edg_q[EAW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_LOAD) begin
            if (phase_q != PH_LOADING) begin
              // New load after a drain: relatch the vertex count and clear the degrees
              nv_d       = nv_eff;
              vtx_d      = '0;
              loaded_d   = '0;
              phase_d    = PH_LOADING;
              clr_load_d = 1'b1;
              state_d    = ST_CLEAR;
            end else begin
              state_d = ST_LOAD;
            end
          end else if (phase_q != PH_DRAINING) begin
            res_d.valid = 1'b1;
            res_d.kind  = KIND_STATUS;
            res_d.err   = ERR_NOT_READY;
          end else if (!in_edges_q) begin
            deg_raddr = vtx_q;
            state_d   = ST_DRDEG;
          end else if (edg_q >= loaded_q) begin
            phase_d     = PH_DONE;
            res_d.valid = 1'b1;
            res_d.kind  = KIND_STATUS;
            res_d.err   = ERR_NOT_READY;
          end else begin
            idx_raddr = edg_q[EAW-1:0];
            state_d   = ST_DRIDX;
          end
        end
      end

      ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = vtx_q;
        deg_wdata = '0;
        if (vtx_q == nv_q) begin
          clr_load_d = 1'b0;
          state_d    = clr_load_q ? ST_LOAD : ST_IDLE;
        end else begin
          vtx_d = vtx_q + VAW'(1);
        end
      end

      ST_LOAD: begin
        if (!in_range || store_full) begin
          // Drop the edge; a last mark still ends the load
          res_d.valid = 1'b1;
          res_d.kind  = KIND_STATUS;
          res_d.err   = !in_range ? ERR_RANGE : ERR_FULL;
          if (it_last_q) begin
            vtx_d   = VAW'(1);
            sum_d   = '0;
            state_d = ST_PFRD;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          arr_we    = 1'b1;
          arr_waddr = loaded_q[EAW-1:0];
          deg_raddr = head_slot;
          loaded_d  = loaded_q + CW'(1);
          state_d   = ST_LDINC;
        end
      end

      ST_LDINC: begin
        deg_we      = 1'b1;
        deg_waddr   = head_slot;
        deg_wdata   = deg_rdata + CW'(1);
        res_d.valid = 1'b1;
        res_d.kind  = KIND_STATUS;
        res_d.err   = ERR_OK;
        if (it_last_q) begin
          vtx_d   = VAW'(1);
          sum_d   = '0;
          state_d = ST_PFRD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_PFRD: begin
        deg_raddr = vtx_q;
        state_d   = ST_PFWR;
      end

      ST_PFWR: begin
        // Turn the count into a start offset; the previous sum seeds the write cursor
        deg_we    = 1'b1;
        deg_waddr = vtx_q;
        deg_wdata = sum_new;
        cur_we    = 1'b1;
        cur_waddr = vtx_m1[CAW-1:0];
        cur_wdata = sum_q;
        sum_d     = sum_new;
        if (vtx_q == nv_q) begin
          edg_d = '0;
          if (loaded_q == '0) begin
            phase_d    = PH_DRAINING;
            vtx_d      = '0;
            in_edges_d = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_SCRD;
          end
        end else begin
          vtx_d   = vtx_q + VAW'(1);
          state_d = ST_PFRD;
        end
      end

      ST_SCRD: begin
        arr_raddr = edg_q[EAW-1:0];
        state_d   = ST_SCCUR;
      end

      ST_SCCUR: begin
        hd_d      = CAW'(arr_rdata.head);
        cur_raddr = CAW'(arr_rdata.head);
        state_d   = ST_SCWR;
      end

      ST_SCWR: begin
        // Arrival order walk keeps equal heads stable
        idx_we    = 1'b1;
        idx_waddr = cur_rdata[EAW-1:0];
        idx_wdata = edg_q[EAW-1:0];
        cur_we    = 1'b1;
        cur_waddr = hd_q;
        cur_wdata = cur_rdata + CW'(1);
        if (edg_is_last) begin
          phase_d    = PH_DRAINING;
          vtx_d      = '0;
          edg_d      = '0;
          in_edges_d = 1'b0;
          state_d    = ST_IDLE;
        end else begin
          edg_d   = edg_q + CW'(1);
          state_d = ST_SCRD;
        end
      end

      ST_DRDEG: begin
        res_d.valid  = 1'b1;
        res_d.kind   = KIND_OFFSET;
        res_d.offset = OFFSET_W'(deg_rdata);
        if (vtx_q == nv_q) begin
          in_edges_d = 1'b1;
          if (loaded_q == '0) begin
            res_d.last = 1'b1;
            phase_d    = PH_DONE;
          end
        end else begin
          vtx_d = vtx_q + VAW'(1);
        end
        state_d = ST_IDLE;
      end

      ST_DRIDX: begin
        arr_raddr = idx_rdata;
        state_d   = ST_DRARR;
      end

      ST_DRARR: begin
        res_d.valid  = 1'b1;
        res_d.kind   = KIND_EDGE;
        res_d.head   = arr_rdata.head;
        res_d.tail   = arr_rdata.tail;
        res_d.weight = arr_rdata.weight;
        if (edg_is_last) begin
          res_d.last = 1'b1;
          phase_d    = PH_DONE;
        end
        edg_d   = edg_q + CW'(1);
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Come out of reset through a full clearing pass of the degree store
      state_q    <= ST_CLEAR;
      phase_q    <= PH_LOADING;
      cfg_nv_q   <= NV_RESET;
      nv_q       <= VAW'(NV_RESET_EFF);
      vtx_q      <= '0;
      edg_q      <= '0;
      loaded_q   <= '0;
      sum_q      <= '0;
      hd_q       <= '0;
      in_edges_q <= 1'b0;
      clr_load_q <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      nv_q       <= nv_d;
      vtx_q      <= vtx_d;
      edg_q      <= edg_d;
      loaded_q   <= loaded_d;
      sum_q      <= sum_d;
      hd_q       <= hd_d;
      in_edges_q <= in_edges_d;
      clr_load_q <= clr_load_d;
      res_q      <= res_d;
      if (cfg_we_i) begin
        cfg_nv_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the accepted item for the load steps
  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_head_q   <= head_i;
      it_tail_q   <= tail_i;
      it_weight_q <= weight_bits_i;
      it_last_q   <= last_edge_i;
    end
  end

  // Per-vertex degree, then start offsets after the prefix pass
  coo2csr_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_VERTICES + 1)
  ) u_deg_ram (
    .clk_i  (clk_i),
    .we_i   (deg_we),
    .waddr_i(deg_waddr),
    .wdata_i(deg_wdata),
    .raddr_i(deg_raddr),
    .rdata_o(deg_rdata)
  );

  // Per-vertex placement cursor for the scatter pass
  coo2csr_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_VERTICES)
  ) u_cur_ram (
    .clk_i  (clk_i),
    .we_i   (cur_we),
    .waddr_i(cur_waddr),
    .wdata_i(cur_wdata),
    .raddr_i(cur_raddr),
    .rdata_o(cur_rdata)
  );

  // Edges in arrival order
  coo2csr_ram #(
    .WIDTH($bits(edge_t)),
    .DEPTH(MAX_EDGES)
  ) u_arr_ram (
    .clk_i  (clk_i),
    .we_i   (arr_we),
    .waddr_i(arr_waddr),
    .wdata_i(arr_wdata),
    .raddr_i(arr_raddr),
    .rdata_o(arr_rdata)
  );

  // Sorted order, held as arrival indices
  coo2csr_ram #(
    .WIDTH(EAW),
    .DEPTH(MAX_EDGES)
  ) u_idx_ram (
    .clk_i  (clk_i),
    .we_i   (idx_we),
    .waddr_i(idx_waddr),
    .wdata_i(idx_wdata),
    .raddr_i(idx_raddr),
    .rdata_o(idx_rdata)
  );

  assign result_valid_o = res_q.valid;
  assign result_kind_o  = res_q.kind;
  assign offset_value_o = res_q.offset;
  assign edge_head_o    = res_q.head;
  assign edge_tail_o    = res_q.tail;
  assign edge_weight_o  = res_q.weight;
  assign last_result_o  = res_q.last;
  assign error_code_o   = res_q.err;

endmodule

// ===== src/coo2csr_chk.sv =====
module coo2csr_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             req_type_i,
  input logic                             result_valid_o,
  input logic [coo2csr_pkg::KIND_W-1:0]   result_kind_o,
  input logic [coo2csr_pkg::OFFSET_W-1:0] offset_value_o,
  input logic [coo2csr_pkg::VERTEX_W-1:0] edge_head_o,
  input logic [coo2csr_pkg::WEIGHT_W-1:0] edge_weight_o,
  input logic                             last_result_o,
  input logic [coo2csr_pkg::ERR_W-1:0]    error_code_o
);

  import coo2csr_pkg::*;

  // An accepted load always takes the block out of idle, so busy is raised
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == REQ_LOAD) |=> busy_o)
    else $error("load item accepted without the block going busy");

  // A result only follows work in progress or an item taken the cycle before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result strobe without a preceding item");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == KIND_STATUS) |->
      (offset_value_o == '0 && edge_head_o == '0 && edge_weight_o == '0))
    else $error("status result carries data");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o != KIND_STATUS) |-> (error_code_o == ERR_OK))
    else $error("data result carries an error code");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |->
      (result_kind_o == KIND_OFFSET || result_kind_o == KIND_EDGE))
    else $error("last mark on a status result");

endmodule

bind coo_to_csr_builder_unit coo2csr_chk u_coo2csr_chk (.*);
